@@ src/active_particle_euler_step_assert.svh @@
// Assertion macros shared by the checker of the particle step block.
`ifndef ACTIVE_PARTICLE_EULER_STEP_ASSERT_SVH
`define ACTIVE_PARTICLE_EULER_STEP_ASSERT_SVH
// Assert that a property holds on every clock edge outside reset.
`define APES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define APES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/apes_pkg.sv @@
// Package: types, constants and trig helper of the particle step block.
package apes_pkg;
	localparam int unsigned TDATA_IN_W  = 192;
	localparam int unsigned TDATA_OUT_W = 176;
	localparam logic [2:0] REG_TIME_STEP  = 3'd0;
	localparam logic [2:0] REG_BOX_WIDTH  = 3'd1;
	localparam logic [2:0] REG_BOX_HEIGHT = 3'd2;
	localparam logic [2:0] REG_WRAP       = 3'd3;
	localparam logic [2:0] REG_DRIVE      = 3'd4;
	localparam logic [2:0] REG_MOBILITY   = 3'd5;
	localparam logic [2:0] REG_NOISE_GAIN = 3'd6;
	localparam logic [31:0] TIME_STEP_RESET = 32'd65536;
	localparam logic [31:0] SIN_A = 32'd1686629713;
	localparam logic [31:0] SIN_B = 32'd693598668;
	localparam logic [31:0] SIN_C = 32'd85569306;
	localparam logic [31:0] SIN_D = 32'd5026995;
	localparam logic [31:0] SIN_E = 32'd172272;

	typedef struct packed {
		logic [31:0] time_step;
		logic [31:0] box_width;
		logic [31:0] box_height;
		logic        wrap_enable;
		logic [63:0] drive_table;
		logic [63:0] mobility_table;
		logic [63:0] noise_gain_table;
	} cfg_t;

	// Quarter-turn argument for sine of heading h: returns x16 (0..65536) and sign.
	function automatic logic [17:0] quarter_arg(input logic [15:0] h);
		logic [16:0] r;
		logic [16:0] x;
		begin
			r = {1'b0, h[13:0], 2'b00};
			x = h[14] ? (17'd65536 - r) : r;
			quarter_arg = {h[15], x};
		end
	endfunction
endpackage

@@ src/apes_sine_pipe.sv @@
// Pipelined quarter-wave sine polynomial, one product per stage.
module apes_sine_pipe (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] x16,
	output logic [16:0] sine
);
	import apes_pkg::*;

	logic [30:0] x_s1;
	logic [30:0] x2_s1;
	logic [31:0] t_s2, t_s3, t_s4, t_s5;
	logic [30:0] x_s2, x_s3, x_s4, x_s5;
	logic [30:0] x2_s2, x2_s3, x2_s4;
	logic [61:0] sq;
	logic [62:0] p2, p3, p4, p5, p6;
	logic [31:0] s_c;

	assign sq = {x16, 14'd0} * {x16, 14'd0};
	assign p2 = x2_s1 * SIN_E;
	assign p3 = x2_s2 * t_s2;
	assign p4 = x2_s3 * t_s3;
	assign p5 = x2_s4 * t_s4;
	assign p6 = x_s5 * t_s5;
	assign s_c = 32'(p6[62:30]) + 32'd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= {x16, 14'd0};
			x2_s1 <= sq[60:30];
			t_s2  <= SIN_D - 32'(p2[62:30]);
			x_s2  <= x_s1;
			x2_s2 <= x2_s1;
			t_s3  <= SIN_C - 32'(p3[62:30]);
			x_s3  <= x_s2;
			x2_s3 <= x2_s2;
			t_s4  <= SIN_B - 32'(p4[62:30]);
			x_s4  <= x_s3;
			x2_s4 <= x2_s3;
			t_s5  <= SIN_A - 32'(p5[62:30]);
			x_s5  <= x_s4;
			sine  <= (s_c[31:14] > 18'd65536) ? 17'd65536 : s_c[30:14];
		end
	end
endmodule

@@ src/apes_cfg_regs.sv @@
// Configuration register file of the particle step block.
module apes_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output apes_pkg::cfg_t    cfg
);
	import apes_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '{time_step: TIME_STEP_RESET, default: '0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIME_STEP:  cfg.time_step <= cfg_data[31:0];
				REG_BOX_WIDTH:  cfg.box_width <= cfg_data[31:0];
				REG_BOX_HEIGHT: cfg.box_height <= cfg_data[31:0];
				REG_WRAP:       cfg.wrap_enable <= cfg_data[0];
				REG_DRIVE:      cfg.drive_table <= cfg_data;
				REG_MOBILITY:   cfg.mobility_table <= cfg_data;
				REG_NOISE_GAIN: cfg.noise_gain_table <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

@@ src/active_particle_euler_step.sv @@
// Top level of the active Brownian particle Euler-Maruyama step block.
// One particle word enters per cycle and one result word leaves per cycle, in
// order, while the output is not stalled. The depth is set by the sine
// polynomial (six stages, one product of up to 31x32 bits each) followed by
// the drive, velocity (split into high and low mobility halves), displacement,
// wrap-and-saturate and output stages. The whole pipeline advances only when
// the output register is empty or being taken, so a stall on the output holds
// every stage and tdata of each in-flight word. Configuration is taken through
// cfg_valid / cfg_ready and must be written only while the pipeline is empty.
module active_particle_euler_step #(
	parameter int TYPE_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x[31:0], pos_y[63:32], heading[79:64], force_x[111:80],
	// force_y[143:112], noise_sample[159:144], age_in[191:160]
	input  logic [apes_pkg::TDATA_IN_W-1:0] s_axis_tdata,
	// cell_kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// new_pos_x[31:0], new_pos_y[63:32], vel_x[95:64], vel_y[127:96],
	// new_heading[143:128], age_out[175:144]
	output logic [apes_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import apes_pkg::*;

	localparam int DEPTH = 12;

	cfg_t cfg;
	logic adv;
	logic [DEPTH-1:0] vld_q;

	assign cfg_ready = 1'b1;
	apes_cfg_regs u_cfg (.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg);

	// advance when the output slot is free or being drained
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// unpack and select the type's coefficients at entry
	logic in_kind;
	assign in_kind = (TYPE_COUNT < 2) ? 1'b0 : s_axis_tuser;
	logic [15:0] h_in;
	assign h_in = s_axis_tdata[79:64];
	logic [17:0] qa_c, qa_s;
	assign qa_c = quarter_arg(h_in + 16'd16384);
	assign qa_s = quarter_arg(h_in);

	logic [16:0] sin_c, sin_s;
	apes_sine_pipe u_cos (.clk, .en(adv), .x16(qa_c[16:0]), .sine(sin_c));
	apes_sine_pipe u_sin (.clk, .en(adv), .x16(qa_s[16:0]), .sine(sin_s));

	// side data delayed alongside the six sine stages
	typedef struct packed {
		logic signed [31:0] px, py, fx, fy;
		logic [15:0] h;
		logic [31:0] drive, mob;
		logic [15:0] hnew;
		logic [31:0] age;
		logic nc, ns;
	} side_t;
	side_t side_d [6];
	side_t side_in;
	logic [31:0] gain_in;
	logic signed [48:0] dh_prod;
	logic [32:0] age_sum;

	assign gain_in = in_kind ? cfg.noise_gain_table[63:32] : cfg.noise_gain_table[31:0];
	assign dh_prod = $signed({1'b0, gain_in}) * $signed(s_axis_tdata[159:144]);
	assign age_sum = {1'b0, s_axis_tdata[191:160]} + {1'b0, cfg.time_step};

	always_comb begin
		side_in.px = s_axis_tdata[31:0];
		side_in.py = s_axis_tdata[63:32];
		side_in.fx = s_axis_tdata[111:80];
		side_in.fy = s_axis_tdata[143:112];
		side_in.h = h_in;
		side_in.drive = in_kind ? cfg.drive_table[63:32] : cfg.drive_table[31:0];
		side_in.mob = in_kind ? cfg.mobility_table[63:32] : cfg.mobility_table[31:0];
		side_in.hnew = h_in + dh_prod[27:12];
		side_in.age = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
		side_in.nc = qa_c[17];
		side_in.ns = qa_s[17];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_in;
			for (int i = 1; i < 6; i++) side_d[i] <= side_d[i-1];
		end
	end

	// stage 7: active term floor(drive*trig/2^16), signed
	side_t sd;
	assign sd = side_d[5];
	logic [48:0] mc, ms;
	assign mc = sd.drive * sin_c;
	assign ms = sd.drive * sin_s;
	logic signed [33:0] ax_c, ay_c;
	assign ax_c = sd.nc ? -$signed({1'b0, mc[48:16]}) - 34'(|mc[15:0]) : $signed({1'b0, mc[48:16]});
	assign ay_c = sd.ns ? -$signed({1'b0, ms[48:16]}) - 34'(|ms[15:0]) : $signed({1'b0, ms[48:16]});

	logic signed [34:0] sx_s7, sy_s7;
	side_t sd_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s7 <= 35'(ax_c) + 35'(sd.fx);
			sy_s7 <= 35'(ay_c) + 35'(sd.fy);
			sd_s7 <= sd;
		end
	end

	// stage 8: partial products with mobility high and low halves
	logic signed [51:0] hx_s8, hy_s8, lx_s8, ly_s8;
	side_t sd_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s8 <= sx_s7 * $signed({1'b0, sd_s7.mob[31:16]});
			hy_s8 <= sy_s7 * $signed({1'b0, sd_s7.mob[31:16]});
			lx_s8 <= sx_s7 * $signed({1'b0, sd_s7.mob[15:0]});
			ly_s8 <= sy_s7 * $signed({1'b0, sd_s7.mob[15:0]});
			sd_s8 <= sd_s7;
		end
	end

	// stage 9: combine and saturate velocity
	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		if (v > 53'sd2147483647) sat32 = 32'sh7FFF_FFFF;
		else if (v < -53'sd2147483648) sat32 = 32'sh8000_0000;
		else sat32 = v[31:0];
	endfunction
	logic signed [31:0] vx_s9, vy_s9;
	side_t sd_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s9 <= sat32(53'(hx_s8) + 53'(lx_s8 >>> 16));
			vy_s9 <= sat32(53'(hy_s8) + 53'(ly_s8 >>> 16));
			sd_s9 <= sd_s8;
		end
	end

	// stage 10: displacement and new wide position
	logic signed [64:0] dx, dy;
	assign dx = vx_s9 * $signed({1'b0, cfg.time_step});
	assign dy = vy_s9 * $signed({1'b0, cfg.time_step});
	logic signed [50:0] px_s10, py_s10;
	logic signed [31:0] vx_s10, vy_s10;
	side_t sd_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s10 <= 51'(sd_s9.px) + 51'(dx >>> 16);
			py_s10 <= 51'(sd_s9.py) + 51'(dy >>> 16);
			vx_s10 <= vx_s9;
			vy_s10 <= vy_s9;
			sd_s10 <= sd_s9;
		end
	end

	// stage 11: one periodic wrap per axis with asymmetric edges
	function automatic logic signed [52:0] wrap(input logic signed [50:0] p,
		input logic [31:0] len);
		logic signed [52:0] l, p2;
		begin
			l = 53'($unsigned(len));
			p2 = 53'(p) <<< 1;
			if (p2 >= l) wrap = 53'(p) - l;
			else if (p2 <= -l) wrap = 53'(p) + l;
			else wrap = 53'(p);
		end
	endfunction
	logic signed [31:0] px_s11, py_s11, vx_s11, vy_s11;
	side_t sd_s11;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s11 <= sat32(cfg.wrap_enable ? wrap(px_s10, cfg.box_width) : 53'(px_s10));
			py_s11 <= sat32(cfg.wrap_enable ? wrap(py_s10, cfg.box_height) : 53'(py_s10));
			vx_s11 <= vx_s10;
			vy_s11 <= vy_s10;
			sd_s11 <= sd_s10;
		end
	end

	// stage 12: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {sd_s11.age, sd_s11.hnew, vy_s11, vx_s11, py_s11, px_s11};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = vld_q[DEPTH-1];
endmodule

@@ src/apes_checker.sv @@
// Port-level checker for the particle step block, bound to the top level.
`include "active_particle_euler_step_assert.svh"
module apes_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [apes_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	input logic cfg_ready
);
	`APES_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")
	`APES_ASSERT(a_ready_free, clk, arst_n, m_axis_tvalid || s_axis_tready,
		"input stalled while output empty")
	`APES_ASSERT(a_stall_tie, clk, arst_n,
		!(m_axis_tvalid && !m_axis_tready) || !s_axis_tready,
		"input taken during output stall")
	`APES_ASSERT(a_cfg_ready, clk, arst_n, cfg_ready, "config port blocked")
endmodule

bind active_particle_euler_step apes_checker u_apes_checker (.*);

@@ test/active_particle_euler_step_test.sv @@
// Self-checking stream testbench for the active particle Euler step block.
module active_particle_euler_step_test;
	import apes_pkg::*;

	// Index past the register file; a write here must change nothing.
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam int unsigned IDLE_LIMIT = 5000;
	// Pipeline depth given by the block, plus margin.
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_PER_PHASE = 200;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] heading;
		logic        kind;
		logic [31:0] force_x;
		logic [31:0] force_y;
		logic [15:0] noise;
		logic [31:0] age;
	} particle_t;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [15:0] heading;
		logic [31:0] age;
	} step_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [TDATA_IN_W-1:0]   s_axis_tdata;
	logic                    s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [TDATA_OUT_W-1:0]  m_axis_tdata;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [2:0]              cfg_index;
	logic [63:0]             cfg_data;

	particle_t particle_queue[$];
	step_t     step_queue[$];
	cfg_t      regs;

	int unsigned errors;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned cfg_writes;
	int unsigned idle_cycles;

	active_particle_euler_step u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint sat_int32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Sine over a quarter turn; argument 0..65536 maps to 0..pi/2, result Q16.16.
	function automatic longint quarter_sin(input logic [16:0] arg);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = 64'(arg) << 14;
		x2 = (x * x) >> 30;
		t  = 64'(SIN_E);
		t  = 64'(SIN_D) - ((x2 * t) >> 30);
		t  = 64'(SIN_C) - ((x2 * t) >> 30);
		t  = 64'(SIN_B) - ((x2 * t) >> 30);
		t  = 64'(SIN_A) - ((x2 * t) >> 30);
		s  = (x * t) >> 30;
		s  = (s + 64'd8192) >> 14;
		if (s > 64'd65536) s = 64'd65536;
		return longint'(s);
	endfunction

	function automatic longint heading_sin(input logic [15:0] h);
		logic [16:0] r;
		r = {1'b0, h[13:0], 2'b00};
		case (h[15:14])
			2'd0: return quarter_sin(r);
			2'd1: return quarter_sin(17'd65536 - r);
			2'd2: return -quarter_sin(r);
			default: return -quarter_sin(17'd65536 - r);
		endcase
	endfunction

	// Mobility is applied as an integer half and a fractional half, the latter floored.
	function automatic longint mobility_scale(input longint sum, input logic [31:0] mob);
		longint whole;
		longint frac;
		whole = sum * longint'(mob[31:16]);
		frac  = (sum * longint'(mob[15:0])) >>> 16;
		return sat_int32(whole + frac);
	endfunction

	// Single periodic fold with the asymmetric half-box edges.
	function automatic longint fold_axis(input longint p, input logic [31:0] len);
		longint l;
		l = longint'({32'b0, len});
		if (2 * p >= l) return p - l;
		if (2 * p <= -l) return p + l;
		return p;
	endfunction

	function automatic step_t euler_step(input particle_t p, input cfg_t c);
		step_t r;
		logic [31:0] drive;
		logic [31:0] mob;
		logic [31:0] gain;
		longint ax;
		longint ay;
		longint vx;
		longint vy;
		longint px;
		longint py;
		longint dh;
		logic [32:0] age_sum;
		drive = p.kind ? c.drive_table[63:32] : c.drive_table[31:0];
		mob   = p.kind ? c.mobility_table[63:32] : c.mobility_table[31:0];
		gain  = p.kind ? c.noise_gain_table[63:32] : c.noise_gain_table[31:0];
		ax = (longint'(drive) * heading_sin(p.heading + 16'd16384)) >>> 16;
		ay = (longint'(drive) * heading_sin(p.heading)) >>> 16;
		vx = mobility_scale(ax + longint'(signed'(p.force_x)), mob);
		vy = mobility_scale(ay + longint'(signed'(p.force_y)), mob);
		px = longint'(signed'(p.pos_x)) + ((vx * longint'(c.time_step)) >>> 16);
		py = longint'(signed'(p.pos_y)) + ((vy * longint'(c.time_step)) >>> 16);
		if (c.wrap_enable) begin
			px = fold_axis(px, c.box_width);
			py = fold_axis(py, c.box_height);
		end
		dh = (longint'(gain) * longint'(signed'(p.noise))) >>> 12;
		age_sum = {1'b0, p.age} + {1'b0, c.time_step};
		r.pos_x   = 32'(sat_int32(px));
		r.pos_y   = 32'(sat_int32(py));
		r.vel_x   = 32'(vx);
		r.vel_y   = 32'(vy);
		r.heading = p.heading + 16'(dh);
		r.age     = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- sender

	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		particle_t p;
		logic      next_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			// A word taken at this edge gets its expectation now, with the current registers.
			if (s_axis_tvalid && s_axis_tready) begin
				p.pos_x   = s_axis_tdata[31:0];
				p.pos_y   = s_axis_tdata[63:32];
				p.heading = s_axis_tdata[79:64];
				p.force_x = s_axis_tdata[111:80];
				p.force_y = s_axis_tdata[143:112];
				p.noise   = s_axis_tdata[159:144];
				p.age     = s_axis_tdata[191:160];
				p.kind    = s_axis_tuser;
				step_queue.push_back(euler_step(p, regs));
				words_in++;
			end
			// Hold a word that is still waiting; otherwise advance or idle.
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (particle_queue.size() > 0) begin
					p = particle_queue.pop_front();
					next_valid = 1'b1;
					s_axis_tdata <= {p.age, p.noise, p.force_y, p.force_x,
						p.heading, p.pos_y, p.pos_x};
					s_axis_tuser <= p.kind;
					if (--burst_left == 0) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left = 64;
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left   = $urandom_range(1, 5);
						end
					end
				end
				s_axis_tvalid <= next_valid;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	int unsigned stall_mode;
	int unsigned stall_count;

	// Cycle between always ready, coin-flip ready and mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode  = 0;
			stall_count = 0;
		end else begin
			if (++stall_count == 97) begin
				stall_count = 0;
				stall_mode  = $urandom_range(0, 2);
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch on result %0d, %s: got %h, want %h", words_out, field, got, want);
		errors++;
	endtask

	// Compare every result word against the oldest expectation.
	always @(posedge clk) begin
		step_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (step_queue.size() == 0) begin
				$display("unexpected result word %h", m_axis_tdata);
				errors++;
			end else begin
				want = step_queue.pop_front();
				if (m_axis_tdata[31:0] !== want.pos_x)
					report_mismatch("new_pos_x", m_axis_tdata[31:0], want.pos_x);
				if (m_axis_tdata[63:32] !== want.pos_y)
					report_mismatch("new_pos_y", m_axis_tdata[63:32], want.pos_y);
				if (m_axis_tdata[95:64] !== want.vel_x)
					report_mismatch("vel_x", m_axis_tdata[95:64], want.vel_x);
				if (m_axis_tdata[127:96] !== want.vel_y)
					report_mismatch("vel_y", m_axis_tdata[127:96], want.vel_y);
				if (m_axis_tdata[143:128] !== want.heading)
					report_mismatch("new_heading", 32'(m_axis_tdata[143:128]),
						32'(want.heading));
				if (m_axis_tdata[175:144] !== want.age)
					report_mismatch("age_out", m_axis_tdata[175:144], want.age);
			end
			words_out++;
		end
	end

	// Stop a hung run: count cycles in which no channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequencing

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TIME_STEP:  regs.time_step        = value[31:0];
			REG_BOX_WIDTH:  regs.box_width        = value[31:0];
			REG_BOX_HEIGHT: regs.box_height       = value[31:0];
			REG_WRAP:       regs.wrap_enable      = value[0];
			REG_DRIVE:      regs.drive_table      = value;
			REG_MOBILITY:   regs.mobility_table   = value;
			REG_NOISE_GAIN: regs.noise_gain_table = value;
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(input logic [31:0] dt, input logic [31:0] bw,
		input logic [31:0] bh, input logic wrap, input logic [63:0] drv,
		input logic [63:0] mob, input logic [63:0] gain);
		write_reg(REG_TIME_STEP, {32'b0, dt});
		write_reg(REG_BOX_WIDTH, {32'b0, bw});
		write_reg(REG_BOX_HEIGHT, {32'b0, bh});
		write_reg(REG_WRAP, {63'b0, wrap});
		write_reg(REG_DRIVE, drv);
		write_reg(REG_MOBILITY, mob);
		write_reg(REG_NOISE_GAIN, gain);
		// Out-of-range index: must be ignored, upper data bits set to catch aliasing.
		write_reg(REG_NONE, {$urandom, $urandom});
	endtask

	// Wait for every word to come back, then let the pipeline empty fully.
	task automatic drain;
		while (particle_queue.size() > 0 || s_axis_tvalid || step_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send(input logic [31:0] px, input logic [31:0] py, input logic [15:0] h,
		input logic k, input logic [31:0] fx, input logic [31:0] fy,
		input logic [15:0] n, input logic [31:0] a);
		particle_t p;
		p.pos_x = px; p.pos_y = py; p.heading = h; p.kind = k;
		p.force_x = fx; p.force_y = fy; p.noise = n; p.age = a;
		@(negedge clk);
		particle_queue.push_back(p);
	endtask

	// Mostly uniform, with the signed extremes weighted in.
	function automatic logic [31:0] pick_word;
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Small signed Q16.16 value within +/- span units.
	function automatic logic [31:0] near(input int unsigned span);
		return $urandom_range(0, 2 * (span << 16)) - (span << 16);
	endfunction

	task automatic send_random(input int unsigned count, input int unsigned span);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send(pick_word(), pick_word(), 16'($urandom), 1'($urandom), pick_word(),
					pick_word(), 16'($urandom), pick_word());
			else
				send(near(span), near(span), 16'($urandom), 1'($urandom), near(4), near(4),
					16'($urandom), $urandom_range(0, 1 << 24));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		cfg_writes = 0;
		idle_cycles = 0;
		regs = '0;
		regs.time_step = TIME_STEP_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset registers: no drive and zero mobility, age advances by one.
		send(32'h0001_0000, 32'hFFFF_0000, 16'd100, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h7FFF, 32'hFFFF_0000);
		send(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b1, 32'd5, 32'd7, 16'h8000, 32'hFFFF_FFFF);
		drain();

		// Zero step with a small box: positions stay put, so the half-box
		// edges decide the fold, including the odd box height.
		load_regs(32'd0, 32'h000A_0000, 32'h0007_0001, 1'b1, {32'h0001_8000, 32'h0003_0000},
			{32'h0002_4000, 32'h0001_0000}, {32'hFFFF_FFFF, 32'h0001_0000});
		send(32'h0005_0000, 32'hFFFC_8000, 16'd0, 1'b0, 32'd0, 32'd0, 16'h7FFF, 32'd0);
		send(32'hFFFB_0000, 32'h0003_8000, 16'd16384, 1'b0, 32'd0, 32'd0, 16'h8000, 32'd1);
		send(32'h0004_FFFF, 32'hFFFC_7FFF, 16'd32768, 1'b1, 32'd0, 32'd0, 16'h1000, 32'd2);
		send(32'hFFFB_0001, 32'h0003_8001, 16'd49152, 1'b1, 32'd0, 32'd0, 16'hF000, 32'd3);
		send(32'h7FFF_FFFF, 32'h8000_0000, 16'd65535, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
			16'd0, 32'hFFFF_FFFF);
		send(32'h8000_0000, 32'h7FFF_FFFF, 16'd8192, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
			16'd1, 32'h0);
		drain();

		// Largest everything: velocity and position saturate, age clamps.
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1, '1, '1);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16'h7FFF, 32'h0000_0001);
		send(32'h8000_0000, 32'h8000_0000, 16'd32768, 1'b1, 32'h8000_0000, 32'h8000_0000,
			16'h8000, 32'hFFFF_FFFF);
		send(32'h0, 32'h0, 16'd24576, 1'b0, 32'h0, 32'h0, 16'hFFFF, 32'h0);
		send_random(RANDOM_PER_PHASE, 1000);
		drain();

		// Ordinary physics in a 40 x 30 box with a fine step.
		load_regs(32'h0000_1000, 32'h0028_0000, 32'h001E_0000, 1'b1,
			{32'h0001_0000, 32'h0002_0000}, {32'h0000_8000, 32'h0001_0000},
			{32'h0000_0800, 32'h0000_0CCD});
		send_random(RANDOM_PER_PHASE, 25);
		drain();

		// Open boundaries, large step, random tables.
		load_regs(32'h0004_0000, $urandom, $urandom, 1'b0, {$urandom, $urandom},
			{$urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18)},
			{$urandom, $urandom});
		send_random(RANDOM_PER_PHASE, 200);
		drain();

		// Wrapping on with a zero-length box, then fully random registers.
		load_regs(32'h0001_0000, 32'd0, 32'd0, 1'b1, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		send_random(RANDOM_PER_PHASE / 2, 50);
		drain();
		load_regs($urandom, $urandom, $urandom, 1'b1, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		send_random(RANDOM_PER_PHASE / 2, 3000);
		drain();

		$display("covered %0d particles and %0d results over %0d register writes,", words_in,
			words_out, cfg_writes);
		$display("from reset values through saturating extremes, folding and open boxes");
		if (errors == 0 && step_queue.size() == 0 && words_in == words_out) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
